/* hw/rtl/cfr_pkg.sv */
`default_nettype none

package cfr_pkg;

    localparam int CFG_TIMER_W = 16;
    localparam int NAME_LEN_W  = 5;
    localparam int PAIR_W      = 7;
    localparam int DIGIT_W     = 4;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_CMD    = 3'd1,
        ST_DIGITS = 3'd2,
        ST_NAME   = 3'd3,
        ST_END    = 3'd4,
        ST_ERROR  = 3'd5
    } parser_state_t;

    typedef enum logic [1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_CHAR_TIMEOUT = 2'd2,
        REG_ERROR_HOLD   = 2'd3
    } cfg_index_t;

    localparam logic [7:0] CH_CMD_START = 8'h31;
    localparam logic [7:0] CH_CMD_STOP  = 8'h32;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

    localparam logic [7:0]             START_MARKER_RST = 8'd36;
    localparam logic [7:0]             END_MARKER_RST   = 8'd35;
    localparam logic [CFG_TIMER_W-1:0] CHAR_TIMEOUT_RST = 16'd1000;
    localparam logic [CFG_TIMER_W-1:0] ERROR_HOLD_RST   = 16'd1000;

    function automatic logic [PAIR_W-1:0] digit_pair(input logic [DIGIT_W-1:0] hi,
                                                     input logic [DIGIT_W-1:0] lo);
        logic [PAIR_W-1:0] h;
        logic [PAIR_W-1:0] l;
        h = PAIR_W'(hi);
        l = PAIR_W'(lo);
        return (h << 3) + (h << 1) + l;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/command_frame_receiver.sv */
`default_nettype none

// Channel  Dir  Handshake             Payload
// s_       in   s_valid / s_ready     s_action, s_rx_byte
// m_       out  m_valid / m_ready     m_state_code .. m_name_length
// cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// Each request is decoded combinationally and its result is registered; it
// appears on the m_ channel the cycle after acceptance.
// A new request is taken every cycle while the result register is empty or
// being drained, so s_ready is low only while a result waits and m_ready is low.
// Synchronous active-low reset restores the register defaults and clears
// the digit store at once. cfg_ready is always high.
module command_frame_receiver #(
    parameter int DIGIT_COUNT = 9,
    parameter int NAME_MAX    = 16,
    parameter int TIMER_BITS  = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic [7:0]                          s_rx_byte,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [2:0]                               m_state_code,
    output logic                                     m_frame_error,
    output logic                                     m_frame_done,
    output logic                                     m_watching,
    output logic                                     m_tx_enable,
    output logic [cfr_pkg::PAIR_W-1:0]               m_temp_min,
    output logic [cfr_pkg::PAIR_W-1:0]               m_temp_max,
    output logic [cfr_pkg::PAIR_W-1:0]               m_soil_humidity,
    output logic [cfr_pkg::PAIR_W-1:0]               m_air_humidity,
    output logic [cfr_pkg::DIGIT_W-1:0]              m_irrigation,
    output logic [cfr_pkg::NAME_LEN_W-1:0]           m_name_length,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [cfr_pkg::CFG_TIMER_W-1:0]     cfg_wdata
);
    import cfr_pkg::*;

    localparam int IDX_MAX = (DIGIT_COUNT > NAME_MAX) ? DIGIT_COUNT : NAME_MAX;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam int DIG_AW  = $clog2(DIGIT_COUNT);
    localparam int CMP_W   = (TIMER_BITS > CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;

    logic [7:0]             cfg_start_reg;
    logic [7:0]             cfg_end_reg;
    logic [CFG_TIMER_W-1:0] cfg_char_tmo_reg;
    logic [CFG_TIMER_W-1:0] cfg_err_hold_reg;

    parser_state_t          state_reg,      state_next;
    logic                   start_mode_reg, start_mode_next;
    logic                   stop_mode_reg,  stop_mode_next;
    logic                   tx_en_reg,      tx_en_next;
    logic                   watching_reg,   watching_next;
    logic [DIGIT_W-1:0]     digit_reg [DIGIT_COUNT];
    logic [DIGIT_W-1:0]     digit_next [DIGIT_COUNT];
    logic [IDX_W-1:0]       char_idx_reg,   char_idx_next;
    logic [NAME_LEN_W-1:0]  name_len_reg,   name_len_next;
    logic [TIMER_BITS-1:0]  char_tmr_reg,   char_tmr_next;
    logic                   char_run_reg,   char_run_next;
    logic [TIMER_BITS-1:0]  err_tmr_reg,    err_tmr_next;

    logic                   err;
    logic                   done;
    logic                   accept;
    logic                   is_digit;
    logic                   is_letter;
    logic [IDX_W-1:0]       name_idx_inc;

    logic                   m_valid_reg;
    logic [2:0]             out_state_reg;
    logic                   out_err_reg;
    logic                   out_done_reg;
    logic                   out_watch_reg;
    logic                   out_tx_reg;
    logic [PAIR_W-1:0]      out_tmin_reg;
    logic [PAIR_W-1:0]      out_tmax_reg;
    logic [PAIR_W-1:0]      out_soil_reg;
    logic [PAIR_W-1:0]      out_air_reg;
    logic [DIGIT_W-1:0]     out_irr_reg;
    logic [NAME_LEN_W-1:0]  out_name_reg;

    function automatic logic [TIMER_BITS-1:0] tmr_inc(input logic [TIMER_BITS-1:0] t);
        return (t != '1) ? t + TIMER_BITS'(1) : t;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_start_reg    <= START_MARKER_RST;
            cfg_end_reg      <= END_MARKER_RST;
            cfg_char_tmo_reg <= CHAR_TIMEOUT_RST;
            cfg_err_hold_reg <= ERROR_HOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                REG_START_MARKER: cfg_start_reg    <= cfg_wdata[7:0];
                REG_END_MARKER:   cfg_end_reg      <= cfg_wdata[7:0];
                REG_CHAR_TIMEOUT: cfg_char_tmo_reg <= cfg_wdata;
                REG_ERROR_HOLD:   cfg_err_hold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign is_digit  = (s_rx_byte >= CH_ZERO) && (s_rx_byte <= CH_NINE);
    assign is_letter = ((s_rx_byte >= CH_UPPER_A) && (s_rx_byte <= CH_UPPER_Z)) ||
                       ((s_rx_byte >= CH_LOWER_A) && (s_rx_byte <= CH_LOWER_Z));
    assign name_idx_inc = (char_idx_reg < IDX_W'(NAME_MAX)) ? char_idx_reg + IDX_W'(1)
                                                            : char_idx_reg;

    always_comb begin
        state_next      = state_reg;
        start_mode_next = start_mode_reg;
        stop_mode_next  = stop_mode_reg;
        tx_en_next      = tx_en_reg;
        watching_next   = watching_reg;
        digit_next      = digit_reg;
        char_idx_next   = char_idx_reg;
        name_len_next   = name_len_reg;
        char_tmr_next   = char_tmr_reg;
        char_run_next   = char_run_reg;
        err_tmr_next    = err_tmr_reg;
        err             = 1'b0;
        done            = 1'b0;

        if (s_action) begin
            if (char_run_reg) begin
                char_tmr_next = tmr_inc(char_tmr_reg);
            end
            if (state_reg == ST_ERROR) begin
                err_tmr_next = tmr_inc(err_tmr_reg);
                if (CMP_W'(err_tmr_next) >= CMP_W'(cfg_err_hold_reg)) begin
                    state_next = ST_HUNT;
                end
            end else if ((state_reg == ST_DIGITS || state_reg == ST_NAME) && char_run_reg &&
                         CMP_W'(char_tmr_next) >= CMP_W'(cfg_char_tmo_reg)) begin
                err = 1'b1;
            end
        end else begin
            unique case (state_reg)
                ST_HUNT: begin
                    if (s_rx_byte == cfg_start_reg) begin
                        char_tmr_next = '0;
                        char_run_next = 1'b1;
                        char_idx_next = '0;
                        name_len_next = '0;
                        state_next    = ST_CMD;
                    end else begin
                        err = 1'b1;
                    end
                end
                ST_CMD: begin
                    if (s_rx_byte == CH_CMD_START) begin
                        start_mode_next = 1'b1;
                        stop_mode_next  = 1'b0;
                        tx_en_next      = 1'b1;
                        char_tmr_next   = '0;
                        char_run_next   = 1'b1;
                        state_next      = ST_DIGITS;
                    end else if (s_rx_byte == CH_CMD_STOP) begin
                        start_mode_next = 1'b0;
                        stop_mode_next  = 1'b1;
                        tx_en_next      = 1'b0;
                        char_tmr_next   = '0;
                        char_run_next   = 1'b1;
                        state_next      = ST_END;
                    end else begin
                        err = 1'b1;
                    end
                end
                ST_DIGITS: begin
                    if (is_digit) begin
                        char_tmr_next = '0;
                        char_run_next = 1'b1;
                        if (char_idx_reg < IDX_W'(DIGIT_COUNT)) begin
                            digit_next[char_idx_reg[DIG_AW-1:0]] =
                                DIGIT_W'(s_rx_byte - CH_ZERO);
                            char_idx_next = char_idx_reg + IDX_W'(1);
                        end
                    end else if (s_rx_byte == CH_AMP) begin
                        char_tmr_next = '0;
                        char_run_next = 1'b1;
                    end else if (s_rx_byte == CH_PERCENT) begin
                        char_tmr_next = '0;
                        char_run_next = 1'b1;
                        char_idx_next = '0;
                        state_next    = ST_NAME;
                    end else begin
                        err = 1'b1;
                    end
                end
                ST_NAME: begin
                    if (is_letter) begin
                        char_tmr_next = '0;
                        char_run_next = 1'b1;
                        char_idx_next = name_idx_inc;
                    end else if (s_rx_byte == CH_AMP) begin
                        char_tmr_next = '0;
                        char_run_next = 1'b0;
                        name_len_next = NAME_LEN_W'(name_idx_inc);
                        char_idx_next = '0;
                        state_next    = ST_END;
                    end else begin
                        err = 1'b1;
                    end
                end
                ST_END: begin
                    if (s_rx_byte == cfg_end_reg) begin
                        if (start_mode_reg) begin
                            watching_next  = 1'b1;
                            stop_mode_next = 1'b0;
                            state_next     = ST_HUNT;
                            done           = 1'b1;
                        end else if (stop_mode_reg) begin
                            watching_next   = 1'b0;
                            start_mode_next = 1'b0;
                            state_next      = ST_HUNT;
                            done            = 1'b1;
                        end
                    end else begin
                        err = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (err) begin
            state_next   = ST_ERROR;
            err_tmr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_HUNT;
            start_mode_reg <= 1'b0;
            stop_mode_reg  <= 1'b1;
            tx_en_reg      <= 1'b0;
            watching_reg   <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                digit_reg[i] <= '0;
            end
            char_idx_reg   <= '0;
            name_len_reg   <= '0;
            char_tmr_reg   <= '0;
            char_run_reg   <= 1'b0;
            err_tmr_reg    <= '0;
        end else if (accept) begin
            state_reg      <= state_next;
            start_mode_reg <= start_mode_next;
            stop_mode_reg  <= stop_mode_next;
            tx_en_reg      <= tx_en_next;
            watching_reg   <= watching_next;
            digit_reg      <= digit_next;
            char_idx_reg   <= char_idx_next;
            name_len_reg   <= name_len_next;
            char_tmr_reg   <= char_tmr_next;
            char_run_reg   <= char_run_next;
            err_tmr_reg    <= err_tmr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_state_reg <= state_next;
            out_err_reg   <= err;
            out_done_reg  <= done;
            out_watch_reg <= watching_next;
            out_tx_reg    <= tx_en_next;
            out_tmin_reg  <= digit_pair(digit_next[0], digit_next[1]);
            out_tmax_reg  <= digit_pair(digit_next[2], digit_next[3]);
            out_soil_reg  <= digit_pair(digit_next[4], digit_next[5]);
            out_air_reg   <= digit_pair(digit_next[6], digit_next[7]);
            out_irr_reg   <= digit_next[8];
            out_name_reg  <= name_len_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_state_code    = out_state_reg;
    assign m_frame_error   = out_err_reg;
    assign m_frame_done    = out_done_reg;
    assign m_watching      = out_watch_reg;
    assign m_tx_enable     = out_tx_reg;
    assign m_temp_min      = out_tmin_reg;
    assign m_temp_max      = out_tmax_reg;
    assign m_soil_humidity = out_soil_reg;
    assign m_air_humidity  = out_air_reg;
    assign m_irrigation    = out_irr_reg;
    assign m_name_length   = out_name_reg;

    a_err_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_error && m_frame_done))
        else $error("frame error and frame done in one result");

    a_err_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_error) |-> (m_state_code == ST_ERROR))
        else $error("frame error without error state");

    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> (m_state_code == ST_HUNT))
        else $error("frame done without return to hunt");

    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted request produced no result");

    a_name_len: assert property (@(posedge aclk) disable iff (!aresetn)
        NAME_LEN_W'(name_len_reg) <= NAME_LEN_W'(NAME_MAX))
        else $error("name length beyond its maximum");

endmodule

`default_nettype wire
